// ===== rtl/c8_pkg.sv =====
// c8_pkg: shared types, command codes and font table for the CHIP-8 instruction core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package c8_pkg;

  localparam int unsigned MemBytes   = 4096;
  localparam int unsigned StackDepth = 16;
  localparam int unsigned ScreenW    = 64;
  localparam int unsigned ScreenH    = 32;
  localparam int unsigned AddrW      = 12;
  localparam int unsigned FontBytes  = 80;
  localparam logic [11:0] FontBase   = 12'h050;
  localparam logic [11:0] ProgBase   = 12'h200;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_EXEC  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  // datapath command from the controller
  typedef enum logic [3:0] {
    CMD_NONE     = 4'd0,
    CMD_CLEAR    = 4'd1,  // clear memory/frame entry at sweep counter
    CMD_WRITE    = 4'd2,  // host byte write
    CMD_FETCH_HI = 4'd3,  // issue fetch of opcode high byte
    CMD_FETCH_LO = 4'd4,  // latch high, issue low
    CMD_DECODE   = 4'd5,  // latch low byte
    CMD_EXEC     = 4'd6,  // instructions that need no steps
    CMD_STEP     = 4'd7,  // one step of a multi-step instruction
    CMD_FINISH   = 4'd8,  // skip, timers, result
    CMD_READ_ROW = 4'd9,
    CMD_RESULT   = 4'd10
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [11:0] cnt;   // sweep / step counter
  } ctrl_t;

  typedef struct packed {
    logic multi;   // decoded instruction needs steps
    logic [4:0] steps;  // index of the last step (counting any read latency step)
  } stat_t;

  function automatic logic [7:0] font_byte(input logic [6:0] idx);
    logic [7:0] t [0:79];
    t = '{8'hF0,8'h90,8'h90,8'h90,8'hF0,8'h20,8'h60,8'h20,8'h20,8'h70,
          8'hF0,8'h10,8'hF0,8'h80,8'hF0,8'hF0,8'h10,8'hF0,8'h10,8'hF0,
          8'h90,8'h90,8'hF0,8'h10,8'h10,8'hF0,8'h80,8'hF0,8'h10,8'hF0,
          8'hF0,8'h80,8'hF0,8'h90,8'hF0,8'hF0,8'h10,8'h20,8'h40,8'h40,
          8'hF0,8'h90,8'hF0,8'h90,8'hF0,8'hF0,8'h90,8'hF0,8'h10,8'hF0,
          8'hF0,8'h90,8'hF0,8'h90,8'h90,8'hE0,8'h90,8'hE0,8'h90,8'hE0,
          8'hF0,8'h80,8'h80,8'h80,8'hF0,8'hE0,8'h90,8'h90,8'h90,8'hE0,
          8'hF0,8'h80,8'hF0,8'h80,8'hF0,8'hF0,8'h80,8'hF0,8'h80,8'h80};
    if (idx < 7'(FontBytes)) return t[idx];
    return 8'h00;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/chip8_instruction_core.sv =====
// CHIP-8 instruction core: one input word per operation, one result word each.
// Dxyn, 00E0, Fx33, Fx55 and Fx65 run as multi-step instructions; one item
// at a time, the next word is taken from the cycle after tvalid rises, once
// the core is idle and no result is held or the held result is being taken.
// Reset (async, active low) clears registers, then a sweep of all 4096 addresses
// loads font and clears memory and frame buffer; no word is accepted meanwhile.
// Depends on c8_pkg, c8_ctrl, c8_datapath, c8_ram.
`timescale 1ns / 1ps
`default_nettype none
module chip8_instruction_core #(
  parameter int unsigned StackDepth = c8_pkg::StackDepth
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // action[1:0], address[13:2], data[21:14], key_mask[37:22], random_byte[45:38]
  input  wire logic [47:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // row_pixels[63:0], program_counter[75:64], executed_opcode[91:76],
  // waiting_for_key[92], sound_on[93]
  output logic [95:0]       m_axis_tdata
);
  import c8_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic [63:0] row;
  logic [11:0] pc;
  logic [15:0] op;
  logic        wk, snd;

  c8_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .action_i(s_axis_tdata[1:0]),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .ctrl_o(ctrl), .stat_i(stat));

  c8_datapath #(.StackDepth(StackDepth)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .address_i(s_axis_tdata[13:2]),
    .data_i(s_axis_tdata[21:14]), .key_mask_i(s_axis_tdata[37:22]),
    .random_byte_i(s_axis_tdata[45:38]),
    .row_pixels_o(row), .program_counter_o(pc), .executed_opcode_o(op),
    .waiting_for_key_o(wk), .sound_on_o(snd));

  assign m_axis_tdata = {2'b00, snd, wk, op, pc, row};
endmodule
`default_nettype wire

// ===== rtl/c8_ram.sv =====
// c8_ram: generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module c8_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [0:Depth-1];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/c8_datapath.sv =====
// c8_datapath: registers, memories, ALU and sprite logic of the CHIP-8 core.
// Depends on c8_pkg and c8_ram.
`timescale 1ns / 1ps
`default_nettype none
module c8_datapath #(
  parameter int unsigned StackDepth = c8_pkg::StackDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire c8_pkg::ctrl_t ctrl_i,
  output c8_pkg::stat_t      stat_o,
  input  wire logic [11:0]   address_i,
  input  wire logic [7:0]    data_i,
  input  wire logic [15:0]   key_mask_i,
  input  wire logic [7:0]    random_byte_i,
  output logic [63:0]        row_pixels_o,
  output logic [11:0]        program_counter_o,
  output logic [15:0]        executed_opcode_o,
  output logic               waiting_for_key_o,
  output logic               sound_on_o
);
  import c8_pkg::*;

  localparam int unsigned SpW = $clog2(StackDepth);

  // latched item
  logic [15:0] keys_q;
  logic [7:0]  rnd_q;
  logic [11:0] addr_q;
  logic [7:0]  wdat_q;

  logic [7:0]  v_q [0:15];
  logic [7:0]  v_d [0:15];
  logic [15:0] i_q, i_d;
  logic [11:0] pc_q, pc_d;
  logic [SpW-1:0] sp_q, sp_d;
  logic [SpW-1:0] sp_inc, sp_dec;
  logic [7:0]  dt_q, dt_d, st_q, st_d;
  logic [11:0] stk_q [0:StackDepth-1];
  logic        stk_we;
  logic [15:0] op_q, op_d;
  logic        skip_q, skip_d, wait_q, wait_d, hit_q, hit_d;

  // memories
  logic        mem_we;
  logic [11:0] mem_a;
  logic [7:0]  mem_wd, mem_rd;
  logic        fb_we;
  logic [4:0]  fb_a;
  logic [63:0] fb_wd, fb_rd;

  c8_ram #(.Width(8), .Depth(MemBytes)) u_mem (
    .clk_i, .we_i(mem_we), .addr_i(mem_a), .wdata_i(mem_wd), .rdata_o(mem_rd));
  c8_ram #(.Width(64), .Depth(ScreenH)) u_fb (
    .clk_i, .we_i(fb_we), .addr_i(fb_a), .wdata_i(fb_wd), .rdata_o(fb_rd));

  // stack pointer wraps modulo the stack depth
  assign sp_inc = (sp_q == SpW'(StackDepth - 1)) ? '0 : sp_q + SpW'(1);
  assign sp_dec = (sp_q == '0) ? SpW'(StackDepth - 1) : sp_q - SpW'(1);

  logic [3:0] x, y, n;
  logic [7:0] kk, vx, vy;
  assign x  = op_q[11:8];
  assign y  = op_q[7:4];
  assign n  = op_q[3:0];
  assign kk = op_q[7:0];
  assign vx = v_q[x];
  assign vy = v_q[y];

  logic [5:0]  xpos;
  logic [4:0]  ypos;
  assign xpos = vx[5:0];
  assign ypos = vy[4:0];

  // step timing for draw: even step 2r issues reads of sprite row r and of the
  // screen row; odd step 2r+1 sees both and writes the screen row if it is on screen.
  logic [4:0] st_idx;
  logic [3:0] row;
  logic [5:0] yrow;
  assign st_idx = ctrl_i.cnt[4:0];
  assign row    = st_idx[4:1];
  assign yrow   = 6'(ypos) + 6'(row);

  // decimal digits of vx
  logic [3:0] d100, d10, d1;
  logic [7:0] rem;
  always_comb begin
    d100 = (vx >= 8'd200) ? 4'd2 : (vx >= 8'd100) ? 4'd1 : 4'd0;
    rem  = vx - 8'(d100) * 8'd100;
    d10  = 4'((16'(rem) * 16'd205) >> 11);
    d1   = 4'(rem - 8'(d10) * 8'd10);
  end

  // key search
  logic       kfound;
  logic [3:0] kidx;
  always_comb begin
    kfound = 1'b0;
    kidx   = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      if (keys_q[k]) begin
        kfound = 1'b1;
        kidx   = 4'(k);
      end
    end
  end

  always_comb begin
    logic [8:0] sum;
    logic [63:0] m;
    logic [11:0] ia;
    v_d    = v_q;
    i_d    = i_q;
    pc_d   = pc_q;
    sp_d   = sp_q;
    dt_d   = dt_q;
    st_d   = st_q;
    op_d   = op_q;
    skip_d = skip_q;
    wait_d = wait_q;
    hit_d  = hit_q;
    stk_we = 1'b0;
    mem_we = 1'b0;
    mem_a  = pc_q;
    mem_wd = 8'h00;
    fb_we  = 1'b0;
    fb_a   = ypos;
    fb_wd  = 64'h0;
    stat_o = '0;
    sum    = 9'h0;
    m      = 64'h0;
    ia     = i_q[11:0] + 12'(st_idx);
    case (op_q[15:12])
      4'hD: begin
        stat_o.multi = 1'b1;
        stat_o.steps = 5'({1'b0, n} << 1);
      end
      4'h0: if (op_q == 16'h00E0) begin
        stat_o.multi = 1'b1;
        stat_o.steps = 5'(ScreenH - 1);
      end
      4'hF: if (kk == 8'h33) begin
        stat_o.multi = 1'b1;
        stat_o.steps = 5'd2;
      end else if (kk == 8'h55) begin
        stat_o.multi = 1'b1;
        stat_o.steps = 5'(x);
      end else if (kk == 8'h65) begin
        stat_o.multi = 1'b1;
        stat_o.steps = 5'(x) + 5'd1;
      end
      default: ;
    endcase

    case (ctrl_i.cmd)
      CMD_CLEAR: begin
        mem_we = 1'b1;
        mem_a  = ctrl_i.cnt;
        mem_wd = (ctrl_i.cnt >= FontBase && ctrl_i.cnt < FontBase + 12'(FontBytes)) ?
                 font_byte(7'(ctrl_i.cnt - FontBase)) : 8'h00;
        fb_we  = 1'b1;
        fb_a   = ctrl_i.cnt[4:0];
      end
      CMD_WRITE: begin
        mem_we = 1'b1;
        mem_a  = addr_q;
        mem_wd = wdat_q;
      end
      CMD_FETCH_HI: begin
        mem_a  = pc_q;
        skip_d = 1'b0;
        wait_d = 1'b0;
        hit_d  = 1'b0;
      end
      CMD_FETCH_LO: begin
        mem_a = pc_q + 12'd1;
        op_d  = {mem_rd, 8'h00};
      end
      CMD_DECODE: begin
        op_d = {op_q[15:8], mem_rd};
        pc_d = pc_q + 12'd2;
        // prime first memory read for multi-cycle ops
        mem_a = i_q[11:0];
      end
      CMD_EXEC: begin
        case (op_q[15:12])
          4'h0: if (op_q == 16'h00EE) begin
            sp_d = sp_dec;
            pc_d = stk_q[sp_dec];
          end
          4'h1: pc_d = op_q[11:0];
          4'h2: begin
            stk_we = 1'b1;
            sp_d   = sp_inc;
            pc_d   = op_q[11:0];
          end
          4'h3: skip_d = (vx == kk);
          4'h4: skip_d = (vx != kk);
          4'h5: skip_d = (n == 4'h0) && (vx == vy);
          4'h6: v_d[x] = kk;
          4'h7: v_d[x] = vx + kk;
          4'h8: begin
            case (n)
              4'h0: v_d[x] = vy;
              4'h1: v_d[x] = vx | vy;
              4'h2: v_d[x] = vx & vy;
              4'h3: v_d[x] = vx ^ vy;
              4'h4: begin
                sum = 9'(vx) + 9'(vy);
                v_d[x] = sum[7:0];
                v_d[15] = {7'h0, sum[8]};
              end
              4'h5: begin
                v_d[x] = vx - vy;
                v_d[15] = {7'h0, vx > vy};
              end
              4'h6: begin
                v_d[x] = vx >> 1;
                v_d[15] = {7'h0, vx[0]};
              end
              4'h7: begin
                v_d[x] = vy - vx;
                v_d[15] = {7'h0, vy > vx};
              end
              4'hE: begin
                v_d[x] = vx << 1;
                v_d[15] = {7'h0, vx[7]};
              end
              default: ;
            endcase
          end
          4'h9: skip_d = (n == 4'h0) && (vx != vy);
          4'hA: i_d = {4'h0, op_q[11:0]};
          4'hB: pc_d = 12'(v_q[0]) + op_q[11:0];
          4'hC: v_d[x] = rnd_q & kk;
          4'hE: begin
            if (kk == 8'h9E) skip_d = (vx < 8'd16) && keys_q[vx[3:0]];
            else if (kk == 8'hA1) skip_d = !((vx < 8'd16) && keys_q[vx[3:0]]);
          end
          4'hF: begin
            case (kk)
              8'h07: v_d[x] = dt_q;
              8'h0A: begin
                if (kfound) v_d[x] = {4'h0, kidx};
                else begin
                  pc_d   = pc_q - 12'd2;
                  wait_d = 1'b1;
                end
              end
              8'h15: dt_d = vx;
              8'h18: st_d = vx;
              8'h1E: i_d = i_q + 16'(vx);
              8'h29: i_d = 16'(FontBase) + 16'(vx) * 16'd5;
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      CMD_STEP: begin
        case (op_q[15:12])
          4'h0: begin
            fb_we = 1'b1;
            fb_a  = ctrl_i.cnt[4:0];
          end
          4'hD: begin
            // even step issues reads of row st_idx/2; odd step writes that row
            if (!st_idx[0]) begin
              mem_a = i_q[11:0] + 12'(row);
              fb_a  = yrow[4:0];
            end else begin
              mem_a = i_q[11:0] + 12'(row);
              fb_a  = yrow[4:0];
              m     = {mem_rd, 56'h0} >> xpos;
              if (yrow < 6'(ScreenH)) begin
                fb_we = 1'b1;
                fb_wd = fb_rd ^ m;
                if ((fb_rd & m) != 64'h0) hit_d = 1'b1;
              end
            end
          end
          default: begin
            case (kk)
              8'h33: begin
                mem_we = 1'b1;
                mem_a  = ia;
                mem_wd = (st_idx == 5'd0) ? {4'h0, d100} :
                         (st_idx == 5'd1) ? {4'h0, d10} : {4'h0, d1};
              end
              8'h55: begin
                mem_we = 1'b1;
                mem_a  = ia;
                mem_wd = v_q[st_idx[3:0]];
              end
              default: begin
                // 65: step k latches byte k-1, issues k
                mem_a = ia;
                if (st_idx != 5'd0) v_d[4'(st_idx - 5'd1)] = mem_rd;
              end
            endcase
          end
        endcase
      end
      CMD_FINISH: begin
        if (op_q[15:12] == 4'hD) v_d[15] = {7'h0, hit_q};
        if (skip_q) pc_d = pc_q + 12'd2;
        if (dt_q != 8'h0) dt_d = dt_q - 8'd1;
        if (st_q != 8'h0) st_d = st_q - 8'd1;
      end
      CMD_READ_ROW: fb_a = addr_q[4:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 16; k++) v_q[k] <= 8'h0;
      for (int k = 0; k < int'(StackDepth); k++) stk_q[k] <= 12'h0;
      i_q    <= 16'h0;
      pc_q   <= ProgBase;
      sp_q   <= '0;
      dt_q   <= 8'h0;
      st_q   <= 8'h0;
      op_q   <= 16'h0;
      skip_q <= 1'b0;
      wait_q <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      v_q    <= v_d;
      i_q    <= i_d;
      pc_q   <= pc_d;
      sp_q   <= sp_d;
      dt_q   <= dt_d;
      st_q   <= st_d;
      op_q   <= op_d;
      skip_q <= skip_d;
      wait_q <= wait_d;
      hit_q  <= hit_d;
      if (stk_we) stk_q[sp_q] <= pc_q;
    end
  end

  // item latch and result registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmd == CMD_RESULT && ctrl_i.cnt == 12'h0) begin
      keys_q <= key_mask_i;
      rnd_q  <= random_byte_i;
      addr_q <= address_i;
      wdat_q <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_pixels_o      <= 64'h0;
      program_counter_o <= ProgBase;
      executed_opcode_o <= 16'h0;
      waiting_for_key_o <= 1'b0;
      sound_on_o        <= 1'b0;
    end else if (ctrl_i.cmd == CMD_RESULT && ctrl_i.cnt != 12'h0) begin
      row_pixels_o      <= (action_e'(ctrl_i.cnt[1:0]) == ACT_READ) ? fb_rd : 64'h0;
      program_counter_o <= pc_q;
      executed_opcode_o <= (action_e'(ctrl_i.cnt[1:0]) == ACT_EXEC) ? op_q : 16'h0;
      waiting_for_key_o <= (action_e'(ctrl_i.cnt[1:0]) == ACT_EXEC) && wait_q;
      sound_on_o        <= st_q != 8'h0;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/c8_ctrl.sv =====
// c8_ctrl: sequencer of the CHIP-8 core; drives datapath commands.
// Depends on c8_pkg.
`timescale 1ns / 1ps
`default_nettype none
module c8_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [1:0]    action_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output c8_pkg::ctrl_t      ctrl_o,
  input  wire c8_pkg::stat_t stat_i
);
  import c8_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_FETCH  = 9'b000000100,
    S_FLO    = 9'b000001000,
    S_DEC    = 9'b000010000,
    S_STEP   = 9'b000100000,
    S_FIN    = 9'b001000000,
    S_RES    = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_e;

  state_e      state_q, state_d;
  logic [11:0] cnt_q, cnt_d;
  logic [1:0]  act_q, act_d;
  logic        ov_q, ov_d;

  assign in_ready_o  = (state_q == S_IDLE) && !(ov_q && !out_ready_i);
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    act_d   = act_q;
    ov_d    = ov_q && !out_ready_i;
    ctrl_o  = '{cmd: CMD_NONE, cnt: 12'h0};
    case (state_q)
      S_CLEAR: begin
        ctrl_o = '{cmd: CMD_CLEAR, cnt: cnt_q};
        cnt_d  = cnt_q + 12'd1;
        if (cnt_q == 12'(MemBytes - 1)) state_d = S_IDLE;
      end
      S_IDLE: if (in_ready_o && in_valid_i) begin
        ctrl_o = '{cmd: CMD_RESULT, cnt: 12'h0};  // latch item
        act_d  = action_i;
        case (action_e'(action_i))
          ACT_WRITE: state_d = S_FETCH;
          ACT_EXEC:  state_d = S_FETCH;
          default:   state_d = S_RES;
        endcase
      end
      S_FETCH: begin
        if (action_e'(act_q) == ACT_WRITE) begin
          ctrl_o  = '{cmd: CMD_WRITE, cnt: 12'h0};
          state_d = S_RES;
        end else begin
          ctrl_o  = '{cmd: CMD_FETCH_HI, cnt: 12'h0};
          state_d = S_FLO;
        end
      end
      S_FLO: begin
        ctrl_o  = '{cmd: CMD_FETCH_LO, cnt: 12'h0};
        state_d = S_DEC;
      end
      S_DEC: begin
        ctrl_o  = '{cmd: CMD_DECODE, cnt: 12'h0};
        state_d = S_STEP;
        cnt_d   = 12'h0;
      end
      S_STEP: begin
        if (!stat_i.multi) begin
          ctrl_o  = '{cmd: CMD_EXEC, cnt: 12'h0};
          state_d = S_FIN;
        end else begin
          ctrl_o = '{cmd: CMD_STEP, cnt: cnt_q};
          cnt_d  = cnt_q + 12'd1;
          if (cnt_q[4:0] >= stat_i.steps) state_d = S_FIN;
        end
      end
      S_FIN: begin
        ctrl_o  = '{cmd: CMD_FINISH, cnt: 12'h0};
        state_d = S_RES;
      end
      S_RES: begin
        // read-row issue; result captured in S_OUT once the output is free
        ctrl_o  = '{cmd: CMD_READ_ROW, cnt: 12'h0};
        state_d = S_OUT;
      end
      S_OUT: begin
        // keep the row read live while the previous result is still held
        ctrl_o = '{cmd: CMD_READ_ROW, cnt: 12'h0};
        if (!ov_q || out_ready_i) begin
          ctrl_o  = '{cmd: CMD_RESULT, cnt: {10'h0, act_q} | 12'h800};
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= 12'h0;
      act_q   <= 2'd0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      act_q   <= act_d;
      ov_q    <= ov_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_ready_o)
    else $error("item taken during clearing pass");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
    else $error("accepted item not started");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> ov_q)
    else $error("result dropped while stalled");
endmodule
`default_nettype wire

// ===== tb/chip8_instruction_core_tb.sv =====
// chip8_instruction_core_tb: self-checking bench for the CHIP-8 instruction core.
// Holds its own interpreter model, a directed table, then random programs written
// and executed a word at a time. Depends on c8_pkg and the core RTL.
`timescale 1ns / 1ps
`default_nettype none
module chip8_instruction_core_tb;
  import c8_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned RandWords  = 1500;

  typedef struct {
    logic [63:0] row;
    logic [11:0] pc;
    logic [15:0] op;
    logic        wt;
    logic        snd;
  } res_t;

  typedef struct {
    action_e     act;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [15:0] keys;
    logic [7:0]  rnd;
    bit          known;
    res_t        res;
  } vec_t;

  localparam logic [7:0] GLYPHS [80] = '{
    8'hF0,8'h90,8'h90,8'h90,8'hF0,8'h20,8'h60,8'h20,8'h20,8'h70,
    8'hF0,8'h10,8'hF0,8'h80,8'hF0,8'hF0,8'h10,8'hF0,8'h10,8'hF0,
    8'h90,8'h90,8'hF0,8'h10,8'h10,8'hF0,8'h80,8'hF0,8'h10,8'hF0,
    8'hF0,8'h80,8'hF0,8'h90,8'hF0,8'hF0,8'h10,8'h20,8'h40,8'h40,
    8'hF0,8'h90,8'hF0,8'h90,8'hF0,8'hF0,8'h90,8'hF0,8'h10,8'hF0,
    8'hF0,8'h90,8'hF0,8'h90,8'h90,8'hE0,8'h90,8'hE0,8'h90,8'hE0,
    8'hF0,8'h80,8'h80,8'h80,8'hF0,8'hE0,8'h90,8'h90,8'h90,8'hE0,
    8'hF0,8'h80,8'hF0,8'h80,8'hF0,8'hF0,8'h80,8'hF0,8'h80,8'h80};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;

  chip8_instruction_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // interpreter state mirrored by the bench
  logic [7:0]  mem_m [MemBytes];
  logic [7:0]  vreg_m [16];
  logic [15:0] idx_m;
  logic [11:0] pc_m;
  logic [11:0] stack_m [StackDepth];
  logic [3:0]  sp_m;
  logic [7:0]  delay_m, sound_m;
  logic [63:0] screen_m [ScreenH];

  res_t        pending_q [$];
  vec_t        dir_tab [$];
  int unsigned n_err = 0;
  int unsigned n_rx = 0;
  int unsigned n_cyc = 0;
  bit          tx_calm = 0, rx_calm = 0;

  task automatic model_reset();
    for (int a = 0; a < MemBytes; a++) mem_m[a] = (a >= 80 && a < 160) ? GLYPHS[a-80] : 8'h00;
    for (int r = 0; r < 16; r++) vreg_m[r] = '0;
    for (int r = 0; r < StackDepth; r++) stack_m[r] = '0;
    for (int r = 0; r < ScreenH; r++) screen_m[r] = '0;
    idx_m = '0; pc_m = ProgBase; sp_m = '0; delay_m = '0; sound_m = '0;
  endtask

  function automatic bit key_down(logic [15:0] keys, logic [7:0] k);
    return k < 8'd16 && keys[k[3:0]];
  endfunction

  // one fetch/decode/execute cycle
  task automatic run_instr(input logic [15:0] keys, input logic [7:0] rnd,
                           output logic [15:0] op, output logic wt);
    logic [3:0]  x, y, n;
    logic [7:0]  kk, vx, vy, res;
    logic [11:0] nnn, a;
    logic [8:0]  sum;
    logic [63:0] msk;
    bit          skip, flag, upd, hit;
    int          yy, j;
    op = {mem_m[pc_m], mem_m[pc_m + 12'd1]};
    x = op[11:8]; y = op[7:4]; n = op[3:0]; kk = op[7:0]; nnn = op[11:0];
    vx = vreg_m[x]; vy = vreg_m[y];
    skip = 0; wt = 0; upd = 0; flag = 0; res = '0;
    pc_m = pc_m + 12'd2;
    case (op[15:12])
      4'h0: begin
        if (op == 16'h00E0) begin
          for (int r = 0; r < ScreenH; r++) screen_m[r] = '0;
        end else if (op == 16'h00EE) begin
          sp_m = sp_m - 4'd1;
          pc_m = stack_m[sp_m];
        end
      end
      4'h1: pc_m = nnn;
      4'h2: begin
        stack_m[sp_m] = pc_m;
        sp_m = sp_m + 4'd1;
        pc_m = nnn;
      end
      4'h3: skip = vx == kk;
      4'h4: skip = vx != kk;
      4'h5: skip = n == 4'h0 && vx == vy;
      4'h6: vreg_m[x] = kk;
      4'h7: vreg_m[x] = vx + kk;
      4'h8: begin
        case (n)
          4'h0: vreg_m[x] = vy;
          4'h1: vreg_m[x] = vx | vy;
          4'h2: vreg_m[x] = vx & vy;
          4'h3: vreg_m[x] = vx ^ vy;
          4'h4: begin sum = vx + vy; res = sum[7:0]; flag = sum[8]; upd = 1; end
          4'h5: begin res = vx - vy; flag = vx > vy; upd = 1; end
          4'h6: begin res = vx >> 1; flag = vx[0]; upd = 1; end
          4'h7: begin res = vy - vx; flag = vy > vx; upd = 1; end
          4'hE: begin res = vx << 1; flag = vx[7]; upd = 1; end
          default: ;
        endcase
        // Vx first, so VF as destination ends up holding the flag
        if (upd) begin
          vreg_m[x] = res;
          vreg_m[15] = {7'd0, flag};
        end
      end
      4'h9: skip = n == 4'h0 && vx != vy;
      4'hA: idx_m = {4'h0, nnn};
      4'hB: pc_m = {4'h0, vreg_m[0]} + nnn;
      4'hC: vreg_m[x] = rnd & kk;
      4'hD: begin
        hit = 0;
        for (int r = 0; r < n; r++) begin
          yy = vy[4:0] + r;
          if (yy >= ScreenH) break;
          a = idx_m[11:0] + 12'(r);
          msk = {mem_m[a], 56'd0} >> vx[5:0];
          if ((screen_m[yy] & msk) != '0) hit = 1;
          screen_m[yy] = screen_m[yy] ^ msk;
        end
        vreg_m[15] = {7'd0, hit};
      end
      4'hE: begin
        if (kk == 8'h9E) skip = key_down(keys, vx);
        else if (kk == 8'hA1) skip = !key_down(keys, vx);
      end
      default: begin
        case (kk)
          8'h07: vreg_m[x] = delay_m;
          8'h0A: begin
            for (j = 0; j < 16; j++) if (keys[j]) break;
            if (j < 16) vreg_m[x] = 8'(j);
            else begin
              pc_m = pc_m - 12'd2;
              wt = 1;
            end
          end
          8'h15: delay_m = vx;
          8'h18: sound_m = vx;
          8'h1E: idx_m = idx_m + {8'd0, vx};
          8'h29: idx_m = 16'h0050 + 16'd5 * {8'd0, vx};
          8'h33: begin
            mem_m[idx_m[11:0]]         = vx / 100;
            mem_m[idx_m[11:0] + 12'd1] = (vx / 10) % 10;
            mem_m[idx_m[11:0] + 12'd2] = vx % 10;
          end
          8'h55: for (int r = 0; r <= x; r++) mem_m[idx_m[11:0] + 12'(r)] = vreg_m[r];
          8'h65: for (int r = 0; r <= x; r++) vreg_m[r] = mem_m[idx_m[11:0] + 12'(r)];
          default: ;
        endcase
      end
    endcase
    if (skip) pc_m = pc_m + 12'd2;
    if (delay_m != 0) delay_m = delay_m - 8'd1;
    if (sound_m != 0) sound_m = sound_m - 8'd1;
  endtask

  task automatic apply_word(input vec_t v, output res_t r);
    logic [15:0] op;
    logic        wt;
    r = '{default: '0};
    case (v.act)
      ACT_WRITE: mem_m[v.addr] = v.data;
      ACT_EXEC: begin
        run_instr(v.keys, v.rnd, op, wt);
        r.op = op;
        r.wt = wt;
      end
      ACT_READ: r.row = screen_m[v.addr[4:0]];
      default: ;
    endcase
    r.pc = pc_m;
    r.snd = sound_m != 0;
  endtask

  function automatic int unsigned draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  // drive one word, hold it until the core takes it, then predict its result
  task automatic send_word(input vec_t v);
    int unsigned gap;
    res_t        r;
    if ($urandom_range(0, 40) == 0) tx_calm = !tx_calm;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, v.rnd, v.keys, v.data, v.addr, v.act};
    do @(posedge clk_i); while (!s_axis_tready);
    apply_word(v, r);
    pending_q.push_back(v.known ? v.res : r);
  endtask

  function automatic void add_row(action_e act, logic [11:0] addr, logic [7:0] data,
                                  logic [15:0] keys, bit known, logic [11:0] pc,
                                  logic [15:0] op, bit wt);
    vec_t v;
    v.act = act; v.addr = addr; v.data = data; v.keys = keys; v.rnd = 8'hA5;
    v.known = known;
    v.res = '{row: '0, pc: pc, op: op, wt: wt, snd: 1'b0};
    dir_tab.push_back(v);
  endfunction

  function automatic logic [15:0] rand_opcode();
    logic [15:0] op;
    logic [7:0]  fk [9] = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65};
    int unsigned p;
    op = 16'($urandom);
    p = $urandom_range(0, 9);
    case (op[15:12])
      4'h0: if (p < 2) op = 16'h00E0; else if (p < 6) op = 16'h00EE;
      4'h5, 4'h9: if (p < 8) op[3:0] = 4'h0;
      4'h8: if (p < 8) op[3:0] = p[3:0]; else if (p == 8) op[3:0] = 4'hE;
      4'hE: if (p < 4) op[7:0] = 8'h9E; else if (p < 8) op[7:0] = 8'hA1;
      4'hF: if (p < 9) op[7:0] = fk[p];
      default: ;
    endcase
    return op;
  endfunction

  function automatic logic [15:0] rand_keys();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'h0001 << $urandom_range(0, 15);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      n_err++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // result side: random stalls plus one long hold-off to back the core up
  initial begin : rx_proc
    int unsigned stall;
    res_t        e;
    forever begin
      if (n_rx == 100) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      if ($urandom_range(0, 40) == 0) rx_calm = !rx_calm;
      stall = draw_gap(rx_calm);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      n_rx++;
      if (pending_q.size() == 0) begin
        n_err++;
        $display("%0t: result with nothing expected, actual %h", $time, m_axis_tdata);
      end else begin
        e = pending_q.pop_front();
        check_field("row_pixels", e.row, m_axis_tdata[63:0]);
        check_field("program_counter", 64'(e.pc), 64'(m_axis_tdata[75:64]));
        check_field("executed_opcode", 64'(e.op), 64'(m_axis_tdata[91:76]));
        check_field("waiting_for_key", 64'(e.wt), 64'(m_axis_tdata[92]));
        check_field("sound_on", 64'(e.snd), 64'(m_axis_tdata[93]));
      end
    end
  end

  always @(posedge clk_i) begin
    n_cyc <= n_cyc + 1;
    if (n_cyc > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : main_proc
    vec_t        v;
    int unsigned n_words;
    int unsigned p;
    logic [15:0] op;
    model_reset();
    // directed: reset view, field extremes, key wait, draw, wrap of the PC
    add_row(ACT_READ,  12'h000, 8'h00, 16'h0000, 1, 12'h200, 16'h0000, 0);
    add_row(ACT_NOP,   12'hFFF, 8'hFF, 16'hFFFF, 1, 12'h200, 16'h0000, 0);
    add_row(ACT_READ,  12'hFFF, 8'h00, 16'h0000, 1, 12'h200, 16'h0000, 0);
    add_row(ACT_WRITE, 12'h200, 8'h60, 16'h0000, 1, 12'h200, 16'h0000, 0);
    add_row(ACT_WRITE, 12'h201, 8'hFF, 16'h0000, 1, 12'h200, 16'h0000, 0);
    add_row(ACT_EXEC,  12'h000, 8'h00, 16'h0000, 1, 12'h202, 16'h60FF, 0);
    add_row(ACT_WRITE, 12'hFFF, 8'hFF, 16'h0000, 1, 12'h202, 16'h0000, 0);
    add_row(ACT_WRITE, 12'h000, 8'h00, 16'h0000, 1, 12'h202, 16'h0000, 0);
    add_row(ACT_EXEC,  12'h000, 8'h00, 16'h0000, 1, 12'h204, 16'h0000, 0);
    add_row(ACT_WRITE, 12'h204, 8'hF0, 16'h0000, 1, 12'h204, 16'h0000, 0);
    add_row(ACT_WRITE, 12'h205, 8'h0A, 16'h0000, 1, 12'h204, 16'h0000, 0);
    add_row(ACT_EXEC,  12'h000, 8'h00, 16'h0000, 1, 12'h204, 16'hF00A, 1);
    add_row(ACT_EXEC,  12'h000, 8'h00, 16'h8000, 1, 12'h206, 16'hF00A, 0);
    add_row(ACT_WRITE, 12'h206, 8'hA0, 16'h0000, 0, '0, '0, 0);
    add_row(ACT_WRITE, 12'h207, 8'h50, 16'h0000, 0, '0, '0, 0);
    add_row(ACT_EXEC,  12'h000, 8'h00, 16'h0000, 0, '0, '0, 0);
    add_row(ACT_WRITE, 12'h208, 8'hD0, 16'h0000, 0, '0, '0, 0);
    add_row(ACT_WRITE, 12'h209, 8'h05, 16'h0000, 0, '0, '0, 0);
    add_row(ACT_EXEC,  12'h000, 8'h00, 16'h0000, 0, '0, '0, 0);
    add_row(ACT_READ,  12'h000, 8'h00, 16'h0000, 0, '0, '0, 0);
    add_row(ACT_WRITE, 12'h20A, 8'h80, 16'h0000, 0, '0, '0, 0);
    add_row(ACT_WRITE, 12'h20B, 8'h0E, 16'h0000, 0, '0, '0, 0);
    add_row(ACT_EXEC,  12'h000, 8'h00, 16'h0000, 0, '0, '0, 0);
    add_row(ACT_WRITE, 12'h20C, 8'h1F, 16'h0000, 0, '0, '0, 0);
    add_row(ACT_WRITE, 12'h20D, 8'hFE, 16'h0000, 0, '0, '0, 0);
    add_row(ACT_EXEC,  12'h000, 8'h00, 16'h0000, 1, 12'hFFE, 16'h1FFE, 0);
    add_row(ACT_EXEC,  12'h000, 8'h00, 16'h0000, 1, 12'h000, 16'h00FF, 0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[k]) send_word(dir_tab[k]);

    // random words, reads and programs: opcode written at the predicted PC, then run
    n_words = 0;
    while (n_words < RandWords) begin
      v.known = 0;
      v.rnd   = 8'($urandom);
      v.keys  = rand_keys();
      v.data  = 8'($urandom);
      v.addr  = 12'($urandom);
      p = $urandom_range(0, 99);
      if (p < 12) begin
        v.act = action_e'($urandom_range(0, 3));
        v.keys = 16'($urandom);
        send_word(v);
        if (v.act != ACT_NOP) n_words++;
      end else if (p < 20) begin
        v.act = ACT_READ;
        send_word(v);
        n_words++;
      end else begin
        op = rand_opcode();
        v.act = ACT_WRITE; v.addr = pc_m; v.data = op[15:8];
        send_word(v);
        v.addr = pc_m + 12'd1; v.data = op[7:0];
        send_word(v);
        v.act = ACT_EXEC; v.addr = 12'($urandom);
        send_word(v);
        n_words += 3;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (n_err == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
